>>> design/pmbv_pkg.sv
// ----------------------------------------------------------------------------
// pmbv_pkg: shared constants and types for the page map engine
// Table sizes and command codes.
// ----------------------------------------------------------------------------
`default_nettype none
package pmbv_pkg;
    localparam int NUM_BLOCKS      = 16;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int LOGICAL_PAGES   = 832;
    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int OFF_W  = $clog2(PAGES_PER_BLOCK);
    localparam int LPN_W  = $clog2(LOGICAL_PAGES);
    localparam int CNT_W  = $clog2(PAGES_PER_BLOCK + 1);
    localparam int FREE_W = $clog2(NUM_BLOCKS + 1);
    localparam int MAP_W  = BLK_W + OFF_W + 1;

    typedef enum logic [2:0] {
        CMD_MAP_WRITE = 3'd0,
        CMD_MAP_READ  = 3'd1,
        CMD_PICK      = 3'd2,
        CMD_ALLOC     = 3'd3,
        CMD_SET_STATE = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_MAX    = 2'd2;
endpackage
`default_nettype wire

>>> design/pmbv_map_ram.sv
// ----------------------------------------------------------------------------
// pmbv_map_ram: logical-to-physical page map storage
// One write port, one registered read port. Entry: mapped flag, block, offset.
// ----------------------------------------------------------------------------
`default_nettype none
module pmbv_map_ram
    import pmbv_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [LPN_W-1:0] waddr,
    input  wire logic [MAP_W-1:0] wdata,
    input  wire logic [LPN_W-1:0] raddr,
    output logic      [MAP_W-1:0] rdata
);
    logic [MAP_W-1:0] mem [LOGICAL_PAGES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/page_map_block_valid_engine.sv
// ----------------------------------------------------------------------------
// page_map_block_valid_engine: page-mapped translation tables with GC support
// One request channel (s_*) carries a command; one result channel (m_*)
// returns exactly one result per request, in order.
// The page map lives in a synchronous RAM; it is cleared after reset by a
// sweep over all LOGICAL_PAGES (832) entries, during which s_ready stays low.
// Block records (valid bitmap, count, state, age, erase count) are flops.
// map_read / map_write first read the RAM, then update the tables;
// pick_victim and alloc_free walk the 16 block records one per cycle;
// set_state updates the block record when the request is taken. One
// request is in work at a time. The result sits in an output register;
// while the receiver stalls the block holds it and accepts no new request.
// ----------------------------------------------------------------------------
`default_nettype none
module page_map_block_valid_engine
    import pmbv_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_cmd,
    input  wire logic [9:0]  s_lpn,
    input  wire logic [3:0]  s_block,
    input  wire logic [5:0]  s_offset,
    input  wire logic [1:0]  s_new_state,
    input  wire logic [4:0]  s_exclude_block,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [3:0]       m_block_out,
    output logic [5:0]       m_offset_out,
    output logic [6:0]       m_count_out,
    output logic [4:0]       m_free_out,
    output logic             m_freed
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_MAP, S_SCAN, S_OUT
    } state_t;

    state_t state_reg;
    logic [LPN_W-1:0] clr_reg;
    logic [2:0]  cmd_reg;
    logic [9:0]  lpn_reg;
    logic [3:0]  blk_reg;
    logic [5:0]  off_reg;
    logic [1:0]  nst_reg;
    logic [4:0]  excl_reg;
    logic [BLK_W:0] idx_reg;
    logic [BLK_W-1:0] ptr_reg;
    logic [31:0] age_reg;
    logic [FREE_W-1:0] free_reg;

    logic [PAGES_PER_BLOCK-1:0] bits_reg [NUM_BLOCKS];
    logic [CNT_W-1:0] cnt_reg   [NUM_BLOCKS];
    logic [1:0]       bst_reg   [NUM_BLOCKS];
    logic [31:0]      erase_reg [NUM_BLOCKS];
    logic [31:0]      stamp_reg [NUM_BLOCKS];

    logic             we;
    logic [LPN_W-1:0] waddr;
    logic [MAP_W-1:0] wdata, rdata;

    // hold the read address on the captured lpn once the request is taken
    wire logic [LPN_W-1:0] raddr = (state_reg == S_IDLE) ? s_lpn[LPN_W-1:0] :
                                                           lpn_reg[LPN_W-1:0];

    pmbv_map_ram u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    wire logic [MAP_W-1:0] code_reg = {1'b1, blk_reg[BLK_W-1:0], off_reg[OFF_W-1:0]};
    wire logic lpn_ok = lpn_reg < 10'(LOGICAL_PAGES);
    wire logic [BLK_W-1:0] pb = rdata[OFF_W+BLK_W-1:OFF_W];
    wire logic [OFF_W-1:0] po = rdata[OFF_W-1:0];
    wire logic [BLK_W-1:0] cur = idx_reg[BLK_W-1:0];
    wire logic [BLK_W-1:0] rr = ptr_reg + cur + BLK_W'(1);

    assign s_ready = (state_reg == S_IDLE);
    assign we    = (state_reg == S_CLEAR) ||
                   (state_reg == S_MAP && cmd_reg == CMD_MAP_WRITE && lpn_ok &&
                    rdata != code_reg);
    assign waddr = (state_reg == S_CLEAR) ? clr_reg : lpn_reg[LPN_W-1:0];
    assign wdata = (state_reg == S_CLEAR) ? '0 : code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            m_valid   <= 1'b0;
            ptr_reg   <= '0;
            age_reg   <= '0;
            free_reg  <= FREE_W'(NUM_BLOCKS);
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                bits_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
                bst_reg[i]   <= ST_CLOSED;
                erase_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + LPN_W'(1);
                    if (clr_reg == LPN_W'(LOGICAL_PAGES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg  <= s_cmd;
                        lpn_reg  <= s_lpn;
                        blk_reg  <= s_block;
                        off_reg  <= s_offset;
                        nst_reg  <= s_new_state;
                        excl_reg <= s_exclude_block;
                        idx_reg  <= '0;
                        m_found      <= (cmd_t'(s_cmd) == CMD_SET_STATE) &&
                                        (s_new_state <= ST_MAX);
                        m_block_out  <= '0;
                        m_offset_out <= '0;
                        m_count_out  <= '0;
                        m_freed      <= 1'b0;
                        case (cmd_t'(s_cmd))
                            CMD_MAP_WRITE, CMD_MAP_READ: state_reg <= S_READ;
                            CMD_PICK, CMD_ALLOC:         state_reg <= S_SCAN;
                            CMD_SET_STATE: begin
                                if (s_new_state <= ST_MAX) begin
                                    bst_reg[s_block]   <= s_new_state;
                                    stamp_reg[s_block] <= age_reg;
                                    age_reg <= age_reg + 32'd1;
                                    if (s_new_state != ST_CLOSED) begin
                                        erase_reg[s_block] <= erase_reg[s_block] + 32'd1;
                                    end
                                end
                                state_reg <= S_OUT;
                            end
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_READ: begin
                    // RAM read of the request lpn lands this cycle
                    state_reg <= S_MAP;
                end
                S_MAP: begin
                    state_reg <= S_OUT;
                    if (cmd_reg == CMD_MAP_READ) begin
                        if (lpn_ok && rdata[MAP_W-1]) begin
                            m_found      <= 1'b1;
                            m_block_out  <= pb;
                            m_offset_out <= po;
                        end
                    end else if (lpn_ok) begin
                        m_found <= 1'b1;
                        if (rdata != code_reg) begin
                            logic [PAGES_PER_BLOCK-1:0] nb;
                            logic [CNT_W-1:0] nc;
                            logic [PAGES_PER_BLOCK-1:0] ob;
                            logic [CNT_W-1:0] oc;
                            logic clr_old;
                            nb = bits_reg[blk_reg];
                            nc = cnt_reg[blk_reg];
                            if (!nb[off_reg]) begin
                                nb[off_reg] = 1'b1;
                                nc = nc + CNT_W'(1);
                            end
                            // old location; when mapped, pb differs from blk_reg or po differs
                            ob = (pb == blk_reg) ? nb : bits_reg[pb];
                            oc = (pb == blk_reg) ? nc : cnt_reg[pb];
                            clr_old = rdata[MAP_W-1] && ob[po];
                            if (clr_old) begin
                                ob[po] = 1'b0;
                                if (oc != '0) oc = oc - CNT_W'(1);
                            end
                            // same block: the old-location write carries both updates
                            if (!(clr_old && pb == blk_reg)) begin
                                bits_reg[blk_reg] <= nb;
                                cnt_reg[blk_reg]  <= nc;
                            end
                            if (clr_old) begin
                                bits_reg[pb] <= ob;
                                cnt_reg[pb]  <= oc;
                                if (oc == '0) begin
                                    m_freed <= 1'b1;
                                    if (free_reg < FREE_W'(NUM_BLOCKS)) begin
                                        free_reg <= free_reg + FREE_W'(1);
                                    end
                                end
                            end
                        end
                    end
                end
                S_SCAN: begin
                    idx_reg <= idx_reg + (BLK_W+1)'(1);
                    if (cmd_reg == CMD_PICK) begin
                        if ({1'b0, cur} != excl_reg && bst_reg[cur] == ST_CLOSED &&
                            cnt_reg[cur] != '0 &&
                            (!m_found || cnt_reg[cur] < m_count_out)) begin
                            m_found     <= 1'b1;
                            m_block_out <= cur;
                            m_count_out <= cnt_reg[cur];
                        end
                    end else if (!m_found && cnt_reg[rr] == '0 &&
                                 bst_reg[rr] == ST_CLOSED) begin
                        m_found     <= 1'b1;
                        m_block_out <= rr;
                        ptr_reg     <= rr;
                        if (free_reg != '0) free_reg <= free_reg - FREE_W'(1);
                    end
                    if (cur == BLK_W'(NUM_BLOCKS - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid) begin
                        m_valid <= 1'b1;
                    end else if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_free_out = free_reg;
endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: request/result testbench for the page map engine
// Drives command requests with random gaps, predicts each result from a
// behavioral copy of the map and block tables, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import pmbv_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic       found;
        logic [3:0] blk;
        logic [5:0] off;
        logic [6:0] cnt;
        logic [4:0] free_cnt;
        logic       freed;
    } answer_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_cmd = '0;
    logic [9:0] s_lpn = '0;
    logic [3:0] s_block = '0;
    logic [5:0] s_offset = '0;
    logic [1:0] s_new_state = '0;
    logic [4:0] s_exclude_block = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_found;
    logic [3:0] m_block_out;
    logic [5:0] m_offset_out;
    logic [6:0] m_count_out;
    logic [4:0] m_free_out;
    logic       m_freed;

    // model tables: map entry 0 means unmapped, else 1 + block*64 + offset
    logic [10:0] map_tbl [LOGICAL_PAGES];
    logic [63:0] valid_map [NUM_BLOCKS];
    int unsigned vcount [NUM_BLOCKS];
    logic [1:0]  bstate [NUM_BLOCKS];
    logic [31:0] erases [NUM_BLOCKS];
    logic [31:0] ages [NUM_BLOCKS];
    logic [31:0] age_ctr;
    int unsigned free_ctr;
    int unsigned rr_ptr;

    answer_t pending_answers[$];
    int      errors = 0;
    int      sent = 0;
    int      checked = 0;
    int      idle_cycles = 0;
    bit      drain_ready_bias = 1'b0;

    page_map_block_valid_engine u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void tables_clear();
        for (int i = 0; i < LOGICAL_PAGES; i++) map_tbl[i] = '0;
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            valid_map[b] = '0;
            vcount[b] = 0;
            bstate[b] = ST_CLOSED;
            erases[b] = '0;
            ages[b] = '0;
        end
        age_ctr = '0;
        free_ctr = NUM_BLOCKS;
        rr_ptr = 0;
    endfunction

    function automatic answer_t predict_command(logic [2:0] c, logic [9:0] lp, logic [3:0] bk,
                                                logic [5:0] of, logic [1:0] ns, logic [4:0] ex);
        answer_t a;
        logic [10:0] code, prv;
        int unsigned pb, po, idx;
        a = '0;
        case (c)
            CMD_MAP_WRITE: begin
                if (lp < LOGICAL_PAGES) begin
                    code = 11'(1 + bk * PAGES_PER_BLOCK + of);
                    prv = map_tbl[lp];
                    a.found = 1'b1;
                    if (prv != code) begin
                        map_tbl[lp] = code;
                        if (!valid_map[bk][of]) begin
                            valid_map[bk][of] = 1'b1;
                            vcount[bk]++;
                        end
                        if (prv != 0) begin
                            pb = (prv - 1) / PAGES_PER_BLOCK;
                            po = (prv - 1) % PAGES_PER_BLOCK;
                            if (valid_map[pb][po]) begin
                                valid_map[pb][po] = 1'b0;
                                if (vcount[pb] > 0) vcount[pb]--;
                                if (vcount[pb] == 0) begin
                                    a.freed = 1'b1;
                                    if (free_ctr < NUM_BLOCKS) free_ctr++;
                                end
                            end
                        end
                    end
                end
            end
            CMD_MAP_READ: begin
                if (lp < LOGICAL_PAGES && map_tbl[lp] != 0) begin
                    a.found = 1'b1;
                    a.blk = 4'((map_tbl[lp] - 1) / PAGES_PER_BLOCK);
                    a.off = 6'((map_tbl[lp] - 1) % PAGES_PER_BLOCK);
                end
            end
            CMD_PICK: begin
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (i != ex && bstate[i] == ST_CLOSED && vcount[i] != 0 &&
                        (!a.found || vcount[i] < a.cnt)) begin
                        a.found = 1'b1;
                        a.blk = 4'(i);
                        a.cnt = 7'(vcount[i]);
                    end
                end
            end
            CMD_ALLOC: begin
                idx = rr_ptr;
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    idx = (idx + 1) % NUM_BLOCKS;
                    if (vcount[idx] == 0 && bstate[idx] == ST_CLOSED) begin
                        a.found = 1'b1;
                        a.blk = 4'(idx);
                        rr_ptr = idx;
                        if (free_ctr > 0) free_ctr--;
                        break;
                    end
                end
            end
            CMD_SET_STATE: begin
                if (ns <= ST_MAX) begin
                    a.found = 1'b1;
                    bstate[bk] = ns;
                    ages[bk] = age_ctr;
                    age_ctr++;
                    if (ns != ST_CLOSED) erases[bk]++;
                end
            end
            default: ;
        endcase
        a.free_cnt = 5'(free_ctr);
        return a;
    endfunction

    task automatic send_request(logic [2:0] c, logic [9:0] lp, logic [3:0] bk,
                                logic [5:0] of, logic [1:0] ns, logic [4:0] ex);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_lpn <= lp;
        s_block <= bk;
        s_offset <= of;
        s_new_state <= ns;
        s_exclude_block <= ex;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_answers.push_back(predict_command(c, lp, bk, of, ns, ex));
        sent++;
    endtask

    task automatic send_random(int unsigned lp_hi);
        int r;
        logic [2:0] c;
        r = $urandom_range(0, 99);
        if (r < 45)      c = CMD_MAP_WRITE;
        else if (r < 65) c = CMD_MAP_READ;
        else if (r < 77) c = CMD_PICK;
        else if (r < 87) c = CMD_ALLOC;
        else if (r < 97) c = CMD_SET_STATE;
        else             c = 3'($urandom_range(5, 7));
        send_request(c, 10'($urandom_range(0, lp_hi)), 4'($urandom),
                     6'($urandom), 2'($urandom), 5'($urandom_range(0, 31)));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    // result side: random stalls, in-order compare
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                checked++;
                if (pending_answers.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    e = pending_answers.pop_front();
                    if (m_found !== e.found) begin
                        $error("found: expected %0d actual %0d", e.found, m_found); errors++;
                    end
                    if (m_block_out !== e.blk) begin
                        $error("block_out: expected %0d actual %0d", e.blk, m_block_out);
                        errors++;
                    end
                    if (m_offset_out !== e.off) begin
                        $error("offset_out: expected %0d actual %0d", e.off, m_offset_out);
                        errors++;
                    end
                    if (m_count_out !== e.cnt) begin
                        $error("count_out: expected %0d actual %0d", e.cnt, m_count_out);
                        errors++;
                    end
                    if (m_free_out !== e.free_cnt) begin
                        $error("free_out: expected %0d actual %0d", e.free_cnt, m_free_out);
                        errors++;
                    end
                    if (m_freed !== e.freed) begin
                        $error("freed: expected %0d actual %0d", e.freed, m_freed); errors++;
                    end
                end
            end
            if (drain_ready_bias) m_ready <= ($urandom_range(0, 9) != 0);
            else m_ready <= ($urandom_range(0, 99) < 60) || ($urandom_range(0, 99) < 5 ? 1'b0 : m_ready);
        end
    end

    // watchdog: covers the clear sweep and long stalls
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(CMD_MAP_READ, 10'd0, 4'd0, 6'd0, 2'd0, 5'd16);
        send_request(CMD_PICK, 10'd0, 4'd0, 6'd0, 2'd0, 5'd16);
        send_request(CMD_MAP_WRITE, 10'd0, 4'd0, 6'd0, 2'd0, 5'd0);
        send_request(CMD_MAP_WRITE, 10'd831, 4'd15, 6'd63, 2'd3, 5'd31);
        send_request(CMD_MAP_WRITE, 10'd0, 4'd0, 6'd0, 2'd0, 5'd0);    // same location
        send_request(CMD_MAP_WRITE, 10'd1023, 4'd1, 6'd1, 2'd0, 5'd0); // lpn out of range
        send_request(CMD_MAP_READ, 10'd831, 4'd0, 6'd0, 2'd0, 5'd0);
        send_request(CMD_MAP_READ, 10'd900, 4'd0, 6'd0, 2'd0, 5'd0);
        send_request(CMD_PICK, 10'd0, 4'd0, 6'd0, 2'd0, 5'd16);
        send_request(CMD_PICK, 10'd0, 4'd0, 6'd0, 2'd0, 5'd0);         // exclude winner
        send_request(CMD_MAP_WRITE, 10'd0, 4'd3, 6'd5, 2'd0, 5'd0);    // empties block 0
        send_request(CMD_ALLOC, 10'd0, 4'd0, 6'd0, 2'd0, 5'd0);
        send_request(CMD_SET_STATE, 10'd0, 4'd15, 6'd0, 2'd2, 5'd0);
        send_request(CMD_SET_STATE, 10'd0, 4'd3, 6'd0, 2'd1, 5'd0);
        send_request(CMD_SET_STATE, 10'd0, 4'd0, 6'd0, 2'd3, 5'd0);    // bad state
        send_request(CMD_PICK, 10'd0, 4'd0, 6'd0, 2'd0, 5'd16);        // no closed victim
        for (int i = 0; i < 16; i++)
            send_request(i < 15 ? CMD_SET_STATE : CMD_ALLOC, 10'd0, 4'(i), 6'd0, 2'd1, 5'd0);
        send_request(3'd7, 10'h3FF, 4'hF, 6'h3F, 2'd3, 5'h1F);         // unknown command
        send_request(3'd5, 10'd0, 4'd0, 6'd0, 2'd0, 5'd0);
        for (int i = 0; i < 16; i++)
            send_request(CMD_SET_STATE, 10'd0, 4'(i), 6'd0, 2'd0, 5'd0);
        wait_drained();
    endtask

    // small lpn range forces rewrites, freed blocks and tied counts
    task automatic test_random_dense(int n);
        for (int i = 0; i < n; i++) send_random(40);
        wait_drained();
    endtask

    task automatic test_random_wide(int n);
        for (int i = 0; i < n; i++) send_random(1023);
        wait_drained();
    endtask

    initial begin
        tables_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_dense(900);
        drain_ready_bias = 1'b1;
        test_random_wide(600);
        $display("Sent %0d requests and checked %0d results over all five commands,",
                 sent, checked);
        $display("with rewrites, freed blocks, victim and allocation searches.");
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> files.f
design/pmbv_pkg.sv
design/pmbv_map_ram.sv
design/page_map_block_valid_engine.sv
tb/tb.sv
